/* sv/rsmb_pkg.sv */
// ----------------------------------------------------------------------------
// Row sliding-mean binarizer package
// Sizes, reset values and beat types shared by the binarizer design.
// ----------------------------------------------------------------------------
package rsmb_pkg;

  localparam int unsigned PIXEL_BITS        = 8;
  localparam int unsigned MAX_HALF_WINDOW   = 7;
  localparam int unsigned HALF_WINDOW_RESET = 4;
  localparam int unsigned CFG_BITS          = 3;

  localparam int unsigned HW_BITS    = $clog2(MAX_HALF_WINDOW + 1);
  localparam int unsigned LINE_DEPTH = MAX_HALF_WINDOW + 1;
  localparam int unsigned COUNT_BITS = $clog2(2 * MAX_HALF_WINDOW + 2);
  localparam int unsigned SUM_BITS   = PIXEL_BITS + COUNT_BITS;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel;
    logic                  row_end;
  } rsmb_in_t;

  typedef struct packed {
    logic foreground;
    logic row_done;
  } rsmb_out_t;

endpackage

/* sv/row_sliding_mean_binarizer.sv */
// ----------------------------------------------------------------------------
// Row sliding-mean binarizer
// Marks each pixel as foreground when it lies above the mean of its row
// window (half_window pixels each side, clipped at the row edges).
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle while the output is not stalled; a row-end
//   beat is followed by half_window flush beats, during which the input stalls.
// Result: a pixel's result is registered in the step that comes half_window
//   processed beats or flush beats after the step that consumes its beat.
// Reset: half_window = 4, window sum, count, line valid bits and handshakes
//   cleared. A half_window write also restarts the current row.
module row_sliding_mean_binarizer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rsmb_pkg::CFG_BITS-1:0]    cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  rsmb_pkg::rsmb_in_t               in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output rsmb_pkg::rsmb_out_t              out_data_o
);

  localparam int unsigned PB = rsmb_pkg::PIXEL_BITS;
  localparam int unsigned HB = rsmb_pkg::HW_BITS;
  localparam int unsigned LD = rsmb_pkg::LINE_DEPTH;
  localparam int unsigned CB = rsmb_pkg::COUNT_BITS;
  localparam int unsigned SB = rsmb_pkg::SUM_BITS;

  logic [HB-1:0]       hw_q, hw_d;
  logic                in_vld_q, in_vld_d;
  rsmb_pkg::rsmb_in_t  in_q;
  logic [HB-1:0]       flush_q, flush_d;

  // line a: ages 0..h (entry h newest, entry 0 the centre)
  // line b: ages h+1..2h+1 (entry 0 leaves the window)
  logic [PB-1:0]       a_pix_q [LD];
  logic [PB-1:0]       a_pix_d [LD];
  logic [PB-1:0]       a_pix_up [LD];
  logic [PB-1:0]       b_pix_q [LD];
  logic [PB-1:0]       b_pix_d [LD];
  logic [PB-1:0]       b_pix_up [LD];
  logic [LD-1:0]       a_vld_q, a_vld_d, a_last_q, a_last_d, b_vld_q, b_vld_d;

  logic [SB-1:0]       sum_q, sum_d;
  logic [CB-1:0]       cnt_q, cnt_d;
  logic [SB-1:0]       prod;

  logic                out_vld_q, out_vld_d;
  rsmb_pkg::rsmb_out_t out_q, out_d;

  logic                out_free, dummy, step, take, emit, row_clear;
  logic [PB-1:0]       x_pix;
  logic                x_vld, x_last;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign dummy      = flush_q != '0;
  assign step       = out_free && (dummy || in_vld_q);
  assign take       = out_free && !dummy && in_vld_q;
  assign in_stall_o = in_vld_q && !take;

  assign x_pix  = dummy ? '0 : in_q.pixel;
  assign x_vld  = !dummy;
  assign x_last = !dummy && in_q.row_end;

  for (genvar g = 0; g < LD; g++) begin : g_up
    if (g < LD - 1) begin : g_mid
      assign a_pix_up[g] = a_pix_q[g+1];
      assign b_pix_up[g] = b_pix_q[g+1];
    end else begin : g_top
      assign a_pix_up[g] = a_pix_q[g];
      assign b_pix_up[g] = b_pix_q[g];
    end
  end

  // shift both lines by one, new pixel enters at entry h
  always_comb begin
    for (int i = 0; i < LD; i++) begin
      if (HB'(i) == hw_q) begin
        a_pix_d[i]  = x_pix;
        a_vld_d[i]  = x_vld;
        a_last_d[i] = x_last;
        b_pix_d[i]  = a_pix_q[0];
        b_vld_d[i]  = a_vld_q[0];
      end else if (HB'(i) < hw_q) begin
        a_pix_d[i]  = a_pix_up[i];
        a_vld_d[i]  = (i < LD - 1) ? a_vld_q[(i+1) % LD] : 1'b0;
        a_last_d[i] = (i < LD - 1) ? a_last_q[(i+1) % LD] : 1'b0;
        b_pix_d[i]  = b_pix_up[i];
        b_vld_d[i]  = (i < LD - 1) ? b_vld_q[(i+1) % LD] : 1'b0;
      end else begin
        a_pix_d[i]  = a_pix_q[i];
        a_vld_d[i]  = 1'b0;
        a_last_d[i] = 1'b0;
        b_pix_d[i]  = b_pix_q[i];
        b_vld_d[i]  = 1'b0;
      end
    end
  end

  always_comb begin
    sum_d = sum_q + (x_vld ? SB'(x_pix) : '0) - (b_vld_d[0] ? SB'(b_pix_d[0]) : '0);
    cnt_d = cnt_q + CB'(x_vld) - CB'(b_vld_d[0]);
    prod  = {{CB{1'b0}}, a_pix_d[0]} * {{PB{1'b0}}, cnt_d};
    emit  = a_vld_d[0];
  end

  assign row_clear = cfg_we_i || (step && emit && a_last_d[0]);

  always_comb begin
    hw_d = hw_q;
    if (cfg_we_i) begin
      if (32'(cfg_wdata_i) > 32'(rsmb_pkg::MAX_HALF_WINDOW)) begin
        hw_d = HB'(rsmb_pkg::MAX_HALF_WINDOW);
      end else begin
        hw_d = HB'(cfg_wdata_i);
      end
    end

    flush_d = flush_q;
    if (cfg_we_i) begin
      flush_d = '0;
    end else if (step) begin
      if (dummy) begin
        flush_d = flush_q - HB'(1);
      end else if (in_q.row_end) begin
        flush_d = hw_q;
      end
    end

    in_vld_d = in_vld_q;
    if (!in_vld_q || take) begin
      in_vld_d = in_valid_i;
    end

    out_vld_d = out_vld_q && out_stall_i;
    out_d     = out_q;
    if (step && emit) begin
      out_vld_d        = 1'b1;
      out_d.foreground = prod > sum_d;
      out_d.row_done   = a_last_d[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q      <= HB'(rsmb_pkg::HALF_WINDOW_RESET);
      in_vld_q  <= 1'b0;
      flush_q   <= '0;
      out_vld_q <= 1'b0;
      a_vld_q   <= '0;
      a_last_q  <= '0;
      b_vld_q   <= '0;
      sum_q     <= '0;
      cnt_q     <= '0;
    end else begin
      hw_q      <= hw_d;
      in_vld_q  <= in_vld_d;
      flush_q   <= flush_d;
      out_vld_q <= out_vld_d;
      if (row_clear) begin
        a_vld_q  <= '0;
        a_last_q <= '0;
        b_vld_q  <= '0;
        sum_q    <= '0;
        cnt_q    <= '0;
      end else if (step) begin
        a_vld_q  <= a_vld_d;
        a_last_q <= a_last_d;
        b_vld_q  <= b_vld_d;
        sum_q    <= sum_d;
        cnt_q    <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && (!in_vld_q || take)) begin
      in_q <= in_data_i;
    end
    if (step) begin
      a_pix_q <= a_pix_d;
      b_pix_q <= b_pix_d;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  a_flush_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (flush_q != '0 && in_vld_q) |-> in_stall_o)
    else $error("input beat consumed during row flush");

  a_count_matches_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) == $countones(a_vld_q) + $countones(b_vld_q[LD-1:1]))
    else $error("window count out of step with line valid bits");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CB'({hw_q, 1'b1}))
    else $error("window count exceeds full window");

  a_row_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && emit && a_last_d[0]) |=> (cnt_q == '0 && sum_q == '0 && a_vld_q == '0))
    else $error("row state not cleared after last result");

endmodule
